>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> design/rrba_pkg.sv
// ----------------------------------------------------------------------------
// rrba_pkg
// Types and codes shared by the rover ring block allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package rrba_pkg;

    localparam int          NEXT_W   = 6;
    localparam logic [5:0]  NO_NEXT  = 6'd63;
    localparam logic [16:0] MAX_DATA = 17'h10000;
    localparam logic [8:0]  MAX_WIDTH = 9'd256;
    localparam logic [23:0] CB_RESET = 24'd65536;

    localparam logic [1:0] OP_FLUSH = 2'd0;
    localparam logic [1:0] OP_ALLOC = 2'd1;
    localparam logic [1:0] OP_FRAME = 2'd2;

    localparam logic [1:0] KIND_EVICT = 2'd0;
    localparam logic [1:0] KIND_ALLOC = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;
    localparam logic [1:0] KIND_DONE  = 2'd3;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_WIDTH = 2'd1;
    localparam logic [1:0] ERR_SIZE  = 2'd2;
    localparam logic [1:0] ERR_LARGE = 2'd3;

    typedef struct packed {
        logic [1:0]  operation;
        logic [8:0]  block_width;
        logic [16:0] data_bytes;
        logic [15:0] owner_tag;
    } t_req;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  error_code;
        logic [15:0] evicted_tag;
        logic [23:0] block_offset;
        logic [23:0] block_bytes;
        logic        thrash;
        logic        last;
    } t_rsp;

    // One block table entry; owner bit 16 marks a present owner.
    typedef struct packed {
        logic [23:0]       offset;
        logic [23:0]       size;
        logic [NEXT_W-1:0] next;
        logic [16:0]       owner;
    } t_row;

    typedef enum logic [3:0] {
        ST_INIT, ST_IDLE, ST_DECODE, ST_FRAME, ST_DONE,
        ST_F_RD, ST_F_CHK, ST_F_INIT,
        ST_A_CHK, ST_A_ERR, ST_A_LD, ST_A_MRG, ST_A_NX, ST_A_SPL, ST_A_WR, ST_A_RES
    } t_state;

    typedef enum logic [2:0] {
        EM_NONE, EM_EVICT, EM_ALLOC, EM_ERROR, EM_DONE
    } t_emit;

    typedef enum logic [1:0] {
        RD_NONE, RD_BLK, RD_NEXT, RD_WALK
    } t_rd_sel;

    typedef struct packed {
        logic    init;
        logic    latch;
        t_emit   emit;
        t_rd_sel rd;
        logic    wrap_pick;
        logic    ld_cur;
        logic    merge;
        logic    split;
        logic    wr_blk;
        logic    frame;
        logic    walk_adv;
    } t_cmd;

    typedef struct packed {
        logic       can_emit;
        logic       err;
        logic [1:0] op;
        logic       walk_ok;
        logic       rd_owned;
        logic       merge_go;
    } t_stat;

endpackage

>>> design/rrba_ctrl.sv
// ----------------------------------------------------------------------------
// rrba_ctrl
// Sequencer for flush, allocate and frame start requests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rrba_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_cfg_valid,
    input  rrba_pkg::t_stat i_stat,
    output rrba_pkg::t_cmd  o_cmd,
    output logic           o_ready,
    output logic           o_cfg_ready
);
    import rrba_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   evict_hold;

    assign evict_hold = i_stat.rd_owned && !i_stat.can_emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: n_state = ST_IDLE;
            ST_IDLE: begin
                if (i_cfg_valid) begin
                    n_state = ST_INIT;
                end else if (i_valid) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (i_stat.op)
                    OP_FLUSH: n_state = ST_F_RD;
                    OP_ALLOC: n_state = ST_A_CHK;
                    OP_FRAME: n_state = ST_FRAME;
                    default:  n_state = ST_DONE;
                endcase
            end
            ST_FRAME: n_state = ST_DONE;
            ST_DONE:  if (i_stat.can_emit) n_state = ST_IDLE;
            ST_F_RD:  n_state = i_stat.walk_ok ? ST_F_CHK : ST_F_INIT;
            ST_F_CHK: if (!evict_hold) n_state = ST_F_RD;
            ST_F_INIT: n_state = ST_DONE;
            ST_A_CHK: n_state = i_stat.err ? ST_A_ERR : ST_A_LD;
            ST_A_ERR: if (i_stat.can_emit) n_state = ST_IDLE;
            ST_A_LD:  if (!evict_hold) n_state = ST_A_MRG;
            ST_A_MRG: n_state = i_stat.merge_go ? ST_A_NX : ST_A_SPL;
            ST_A_NX:  if (!evict_hold) n_state = ST_A_MRG;
            ST_A_SPL: n_state = ST_A_WR;
            ST_A_WR:  n_state = ST_A_RES;
            ST_A_RES: if (i_stat.can_emit) n_state = ST_IDLE;
            default:  n_state = ST_INIT;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_cmd.emit  = EM_NONE;
        o_cmd.rd    = RD_NONE;
        o_ready     = 1'b0;
        o_cfg_ready = 1'b0;
        case (r_state)
            ST_INIT: o_cmd.init = 1'b1;
            ST_IDLE: begin
                o_cfg_ready = 1'b1;
                o_ready     = !i_cfg_valid;
                o_cmd.latch = i_valid && !i_cfg_valid;
            end
            ST_FRAME: o_cmd.frame = 1'b1;
            ST_DONE:  if (i_stat.can_emit) o_cmd.emit = EM_DONE;
            ST_F_RD:  if (i_stat.walk_ok) o_cmd.rd = RD_WALK;
            ST_F_CHK: begin
                if (!evict_hold) begin
                    o_cmd.walk_adv = 1'b1;
                    if (i_stat.rd_owned) o_cmd.emit = EM_EVICT;
                end
            end
            ST_F_INIT: o_cmd.init = 1'b1;
            ST_A_CHK: begin
                if (!i_stat.err) begin
                    o_cmd.wrap_pick = 1'b1;
                    o_cmd.rd        = RD_BLK;
                end
            end
            ST_A_ERR: if (i_stat.can_emit) o_cmd.emit = EM_ERROR;
            ST_A_LD: begin
                if (!evict_hold) begin
                    o_cmd.ld_cur = 1'b1;
                    if (i_stat.rd_owned) o_cmd.emit = EM_EVICT;
                end
            end
            ST_A_MRG: if (i_stat.merge_go) o_cmd.rd = RD_NEXT;
            ST_A_NX: begin
                if (!evict_hold) begin
                    o_cmd.merge = 1'b1;
                    if (i_stat.rd_owned) o_cmd.emit = EM_EVICT;
                end
            end
            ST_A_SPL: o_cmd.split  = 1'b1;
            ST_A_WR:  o_cmd.wr_blk = 1'b1;
            ST_A_RES: if (i_stat.can_emit) o_cmd.emit = EM_ALLOC;
            default: ;
        endcase
    end

endmodule

>>> design/rrba_dp.sv
// ----------------------------------------------------------------------------
// rrba_dp
// Block table memory, rover and frame flags, and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rrba_dp #(
    parameter int BLOCK_SLOTS  = 32,
    parameter int HEADER_BYTES = 64,
    parameter int SPLIT_MIN    = 256
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rrba_pkg::t_cmd  i_cmd,
    input  rrba_pkg::t_req  i_req,
    input  logic            i_cfg_we,
    input  logic [23:0]     i_cfg_data,
    input  logic            i_ready,
    output rrba_pkg::t_stat o_stat,
    output rrba_pkg::t_rsp  o_rsp,
    output logic            o_valid
);
    import rrba_pkg::*;

    localparam int SW = $clog2(BLOCK_SLOTS);
    localparam int NW = $clog2(BLOCK_SLOTS + 1);
    localparam logic [NEXT_W-1:0] SLOTS_L = NEXT_W'(BLOCK_SLOTS);
    localparam logic [NW-1:0]     SLOTS_N = NW'(BLOCK_SLOTS);

    t_row mem [BLOCK_SLOTS];

    logic [23:0]            r_cb;
    t_req                   r_req;
    logic [NEXT_W-1:0]      r_rover;
    logic                   r_rv;
    logic [23:0]            r_roff;
    logic [23:0]            r_start;
    logic                   r_wrap;
    logic                   r_thrash;
    logic [BLOCK_SLOTS-1:0] r_in_use;
    logic [NEXT_W-1:0]      r_blk;
    logic                   r_wnow;
    logic [NW-1:0]          r_n;
    logic [NEXT_W-1:0]      r_walk;
    t_row                   r_cur;
    t_row                   r_rdata;
    t_rsp                   r_out;
    logic                   r_ovalid;

    logic [23:0]       size_sum;
    logic [23:0]       size_c;
    logic [1:0]        err_c;
    logic              wrap_c;
    logic [NEXT_W-1:0] blk_c;
    logic              can_emit;
    logic              free_ok;
    logic [NEXT_W-1:0] free_idx;
    logic              split_c;
    logic              next_ok;
    logic [23:0]       pos_c;
    logic [23:0]       left_c;
    logic              rd_en;
    logic [NEXT_W-1:0] rd_addr;
    logic              wr_en;
    logic [NEXT_W-1:0] wr_addr;
    t_row              wr_row;
    t_rsp              rsp_c;

    assign size_sum = 24'(HEADER_BYTES) + {7'd0, r_req.data_bytes} + 24'd3;
    assign size_c   = {size_sum[23:2], 2'b00};

    always_comb begin
        if (r_req.block_width > MAX_WIDTH) begin
            err_c = ERR_WIDTH;
        end else if (r_req.data_bytes == '0 || r_req.data_bytes > MAX_DATA) begin
            err_c = ERR_SIZE;
        end else if (size_c > r_cb) begin
            err_c = ERR_LARGE;
        end else begin
            err_c = ERR_NONE;
        end
    end

    assign wrap_c   = !r_rv || (r_rover >= SLOTS_L) || (r_roff > r_cb - size_c);
    assign blk_c    = wrap_c ? '0 : r_rover;
    assign can_emit = !r_ovalid || i_ready;
    assign next_ok  = r_cur.next < SLOTS_L;
    assign pos_c    = (r_rv && r_rover < SLOTS_L) ? r_roff : r_cb;
    assign left_c   = r_cur.size - size_c;
    assign split_c  = (r_cur.size >= size_c) && (left_c > 24'(SPLIT_MIN)) && free_ok;

    // Lowest free slot.
    always_comb begin
        free_ok  = 1'b0;
        free_idx = '0;
        for (int i = BLOCK_SLOTS - 1; i >= 0; i--) begin
            if (!r_in_use[i]) begin
                free_ok  = 1'b1;
                free_idx = NEXT_W'(i);
            end
        end
    end

    always_comb begin
        o_stat.can_emit = can_emit;
        o_stat.err      = err_c != ERR_NONE;
        o_stat.op       = r_req.operation;
        o_stat.walk_ok  = (r_walk < SLOTS_L) && (r_n < SLOTS_N);
        o_stat.rd_owned = r_rdata.owner[16];
        o_stat.merge_go = (r_cur.size < size_c) && (r_n < SLOTS_N) && next_ok;
    end

    // Table read port.
    always_comb begin
        rd_en   = 1'b1;
        rd_addr = '0;
        case (i_cmd.rd)
            RD_BLK:  rd_addr = blk_c;
            RD_NEXT: rd_addr = r_cur.next;
            RD_WALK: rd_addr = r_walk;
            default: rd_en = 1'b0;
        endcase
    end

    // Table write port.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_row  = r_cur;
        if (i_cmd.init) begin
            wr_en  = 1'b1;
            wr_row = '{offset: '0, size: r_cb, next: NO_NEXT, owner: '0};
        end else if (i_cmd.split && split_c) begin
            wr_en   = 1'b1;
            wr_addr = free_idx;
            wr_row  = '{offset: r_cur.offset + size_c, size: left_c,
                        next: r_cur.next, owner: '0};
        end else if (i_cmd.wr_blk) begin
            wr_en        = 1'b1;
            wr_addr      = r_blk;
            wr_row.owner = {1'b1, r_req.owner_tag};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr[SW-1:0]] <= wr_row;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr[SW-1:0]];
        end
    end

    always_comb begin
        rsp_c        = '0;
        rsp_c.thrash = r_thrash;
        case (i_cmd.emit)
            EM_EVICT: begin
                rsp_c.kind        = KIND_EVICT;
                rsp_c.evicted_tag = r_rdata.owner[15:0];
            end
            EM_ALLOC: begin
                rsp_c.kind         = KIND_ALLOC;
                rsp_c.block_offset = r_cur.offset;
                rsp_c.block_bytes  = r_cur.size;
                rsp_c.last         = 1'b1;
            end
            EM_ERROR: begin
                rsp_c.kind       = KIND_ERROR;
                rsp_c.error_code = err_c;
                rsp_c.last       = 1'b1;
            end
            EM_DONE: begin
                rsp_c.kind = KIND_DONE;
                rsp_c.last = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit != EM_NONE) begin
            r_out <= rsp_c;
        end
        if (i_cmd.latch) begin
            r_req <= i_req;
        end
        if (i_cmd.ld_cur) begin
            r_cur <= r_rdata;
        end else if (i_cmd.merge) begin
            r_cur.size <= r_cur.size + r_rdata.size;
            r_cur.next <= r_rdata.next;
        end else if (i_cmd.split && split_c) begin
            r_cur.next <= free_idx;
            r_cur.size <= size_c;
        end
        if (i_cmd.wrap_pick) begin
            r_blk  <= blk_c;
            r_wnow <= wrap_c && r_rv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cb     <= CB_RESET;
            r_rover  <= '0;
            r_rv     <= 1'b1;
            r_roff   <= '0;
            r_start  <= '0;
            r_wrap   <= 1'b0;
            r_thrash <= 1'b0;
            r_in_use <= BLOCK_SLOTS'(1);
            r_n      <= '0;
            r_walk   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cb <= i_cfg_data;
            end
            if (i_cmd.emit != EM_NONE) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cmd.init) begin
                r_in_use <= BLOCK_SLOTS'(1);
                r_rover  <= '0;
                r_rv     <= 1'b1;
                r_roff   <= '0;
            end
            if (i_cmd.latch) begin
                r_walk <= '0;
                r_n    <= '0;
            end
            if (i_cmd.walk_adv) begin
                r_walk <= r_rdata.next;
                r_n    <= r_n + 1'b1;
            end
            if (i_cmd.wrap_pick) begin
                r_n <= '0;
            end
            if (i_cmd.merge) begin
                r_in_use[r_cur.next[SW-1:0]] <= 1'b0;
                r_n <= r_n + 1'b1;
            end
            if (i_cmd.split) begin
                if (split_c) begin
                    r_in_use[free_idx[SW-1:0]] <= 1'b1;
                    r_rover <= free_idx;
                    r_rv    <= 1'b1;
                    r_roff  <= r_cur.offset + size_c;
                end else begin
                    r_rover <= next_ok ? r_cur.next : '0;
                    r_rv    <= next_ok;
                    // blocks tile the region: the next one starts here
                    r_roff  <= r_cur.offset + r_cur.size;
                end
            end
            if (i_cmd.wr_blk) begin
                if (r_wrap) begin
                    if (r_wnow || pos_c >= r_start) r_thrash <= 1'b1;
                end else if (r_wnow) begin
                    r_wrap <= 1'b1;
                end
            end
            if (i_cmd.frame) begin
                r_start  <= pos_c;
                r_wrap   <= 1'b0;
                r_thrash <= 1'b0;
            end
        end
    end

    assign o_rsp   = r_out;
    assign o_valid = r_ovalid;

    `ASSERT_IMPLY(a_emit_room, i_clk, i_rst_n, i_cmd.emit != EM_NONE, can_emit, "emit with result register full")
    `ASSERT_ALWAYS(a_slot0_used, i_clk, i_rst_n, r_in_use[0], "slot zero released")
    `ASSERT_IMPLY(a_rover_ok, i_clk, i_rst_n, r_rv, r_rover < SLOTS_L, "rover outside table")
    `ASSERT_IMPLY(a_thrash_wrap, i_clk, i_rst_n, r_thrash && !i_cmd.frame, r_wrap, "thrash without wrap")

endmodule

>>> design/rover_ring_block_allocator_unit.sv
// Rover ring block allocator. One request is taken at a time, and the next is
// refused until the last result of the current one has been registered. Each
// table block that a flush walks or an allocation merges takes a registered
// table read and then a step that acts on the data. Each result waits in the
// output register until it is taken. While it waits, the next result holds the
// sequence, so receiver stalls add directly to the length of an operation.
// ----------------------------------------------------------------------------
// rover_ring_block_allocator_unit
// Top level: request, result and cache size register channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rover_ring_block_allocator_unit #(
    parameter int BLOCK_SLOTS  = 32,
    parameter int HEADER_BYTES = 64,
    parameter int SPLIT_MIN    = 256
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  rrba_pkg::t_req i_req,
    output logic           o_valid,
    input  logic           i_ready,
    output rrba_pkg::t_rsp o_rsp,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [23:0]    i_cfg_data
);
    import rrba_pkg::*;

    t_cmd cmd;
    t_stat stat;

    rrba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_cfg_valid (i_cfg_valid),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_ready     (o_ready),
        .o_cfg_ready (o_cfg_ready)
    );

    rrba_dp #(
        .BLOCK_SLOTS  (BLOCK_SLOTS),
        .HEADER_BYTES (HEADER_BYTES),
        .SPLIT_MIN    (SPLIT_MIN)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_req      (i_req),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_ready    (i_ready),
        .o_stat     (stat),
        .o_rsp      (o_rsp),
        .o_valid    (o_valid)
    );

endmodule
